// ----- sv/csim_pkg.sv -----
// ----------------------------------------------------------------------------
// csim_pkg
// Shared constants and types for the cosine similarity engine.
// ----------------------------------------------------------------------------
package csim_pkg;

    localparam int MAX_LEN     = 4096;
    localparam int SAMPLE_BITS = 16;
    localparam int ELEM_W      = 16;
    localparam int SIM_OUT_W   = 16;

    localparam int FRAC_BITS  = SAMPLE_BITS - 1;
    localparam int PROD_W     = 2 * SAMPLE_BITS;
    localparam int CNT_W      = $clog2(MAX_LEN + 1);
    localparam int NORM_W     = PROD_W - 2 + CNT_W;
    localparam int DOT_W      = NORM_W + 1;
    localparam int MAG_W      = FRAC_BITS + 1;
    localparam int SIM_W      = SAMPLE_BITS + 1;
    localparam int ROOT_SHIFT = 2 * FRAC_BITS;
    localparam int WIDE_W     = 2 * NORM_W + ROOT_SHIFT + 2;
    localparam int STEP_W     = $clog2(NORM_W + 1);

    typedef struct packed {
        logic signed [ELEM_W-1:0] elem_a;
        logic signed [ELEM_W-1:0] elem_b;
        logic                     last;
    } csim_in_t;

    typedef struct packed {
        logic signed [SIM_OUT_W-1:0] similarity;
        logic                        zero_norm;
        logic                        length_overflow;
    } csim_out_t;

    typedef struct packed {
        logic [NORM_W-1:0] dmag;
        logic [NORM_W-1:0] norm_a;
        logic [NORM_W-1:0] norm_b;
    } csim_ratio_req_t;

endpackage

// ----- sv/csim_ratio.sv -----
// ----------------------------------------------------------------------------
// csim_ratio
// Iterative quotient unit: largest m with m^2 * na * nb <= dmag^2 * 2^(2F).
// One wide adder forms both products by shift-add, then the root search.
// ----------------------------------------------------------------------------
module csim_ratio
    import csim_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  csim_ratio_req_t      req,
    output logic                 done,
    output logic [MAG_W-1:0]     mag
);

    localparam logic [2:0] R_IDLE = 3'd0;
    localparam logic [2:0] R_MULP = 3'd1;
    localparam logic [2:0] R_SETD = 3'd2;
    localparam logic [2:0] R_MULD = 3'd3;
    localparam logic [2:0] R_SETR = 3'd4;
    localparam logic [2:0] R_RTA  = 3'd5;
    localparam logic [2:0] R_RTB  = 3'd6;
    localparam logic [2:0] R_RTC  = 3'd7;

    logic [2:0]        state_reg, state_next;
    logic [STEP_W-1:0] cnt_reg, cnt_next;
    logic              done_reg, done_next;

    logic [WIDE_W-1:0] a_reg, a_next;
    logic [WIDE_W-1:0] b_reg, b_next;
    logic [WIDE_W-1:0] c_reg, c_next;
    logic [WIDE_W-1:0] t_reg, t_next;
    logic [NORM_W-1:0] mplier_reg, mplier_next;
    logic [NORM_W-1:0] dmag_reg, dmag_next;
    logic [MAG_W-1:0]  m_reg, m_next;
    logic              flag_reg, flag_next;

    logic [WIDE_W-1:0] op_a;
    logic [WIDE_W-1:0] op_b;
    logic              sub;
    logic [WIDE_W:0]   sum;

    // shared adder / subtractor
    always_comb
    begin
        op_a = a_reg;
        op_b = b_reg;
        sub  = 1'b0;
        case (state_reg)
            R_RTA:
            begin
                op_a = c_reg;
            end
            R_RTB:
            begin
                op_b = t_reg;
                sub  = 1'b1;
            end
            R_RTC:
            begin
                op_a = t_reg;
            end
            default:
            begin
                op_a = a_reg;
            end
        endcase
        sum = {1'b0, op_a} + {1'b0, (sub ? ~op_b : op_b)} + (WIDE_W + 1)'(sub);
    end

    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        done_next   = 1'b0;
        a_next      = a_reg;
        b_next      = b_reg;
        c_next      = c_reg;
        t_next      = t_reg;
        mplier_next = mplier_reg;
        dmag_next   = dmag_reg;
        m_next      = m_reg;
        flag_next   = flag_reg;
        case (state_reg)
            R_IDLE:
            begin
                if (start)
                begin
                    a_next      = '0;
                    b_next      = WIDE_W'(req.norm_b);
                    mplier_next = req.norm_a;
                    dmag_next   = req.dmag;
                    cnt_next    = '0;
                    state_next  = R_MULP;
                end
            end
            R_MULP, R_MULD:
            begin
                if (mplier_reg[0])
                begin
                    a_next = sum[WIDE_W-1:0];
                end
                b_next      = b_reg << 1;
                mplier_next = mplier_reg >> 1;
                cnt_next    = cnt_reg + 1'b1;
                if (cnt_reg == STEP_W'(NORM_W - 1))
                begin
                    state_next = (state_reg == R_MULP) ? R_SETD : R_SETR;
                end
            end
            R_SETD:
            begin
                c_next      = a_reg;
                a_next      = '0;
                b_next      = WIDE_W'(dmag_reg);
                mplier_next = dmag_reg;
                cnt_next    = '0;
                state_next  = R_MULD;
            end
            R_SETR:
            begin
                a_next     = a_reg << ROOT_SHIFT;
                b_next     = c_reg << ROOT_SHIFT;
                c_next     = '0;
                m_next     = '0;
                cnt_next   = '0;
                state_next = R_RTA;
            end
            R_RTA:
            begin
                t_next     = sum[WIDE_W-1:0];
                state_next = R_RTB;
            end
            R_RTB:
            begin
                flag_next = sum[WIDE_W];
                if (sum[WIDE_W])
                begin
                    a_next = sum[WIDE_W-1:0];
                end
                state_next = R_RTC;
            end
            R_RTC:
            begin
                c_next   = (flag_reg ? sum[WIDE_W-1:0] : c_reg) >> 1;
                b_next   = b_reg >> 2;
                m_next   = {m_reg[MAG_W-2:0], flag_reg};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == STEP_W'(MAG_W - 1))
                begin
                    done_next  = 1'b1;
                    state_next = R_IDLE;
                end
                else
                begin
                    state_next = R_RTA;
                end
            end
            default:
            begin
                state_next = R_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= R_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg      <= a_next;
        b_reg      <= b_next;
        c_reg      <= c_next;
        t_reg      <= t_next;
        mplier_reg <= mplier_next;
        dmag_reg   <= dmag_next;
        m_reg      <= m_next;
        flag_reg   <= flag_next;
    end

    assign done = done_reg;
    assign mag  = m_reg;

endmodule

// ----- sv/cosine_similarity_engine_top.sv -----
// ----------------------------------------------------------------------------
// cosine_similarity_engine_top
// Cosine similarity of two streamed vectors, signed Q1.15 in and out.
// ----------------------------------------------------------------------------
// Input channel (item, item_valid, item_stall): one element pair per
// transaction, with last on the final pair. Each pair is accepted, then one
// 16x16 multiplier and one accumulator adder work through a*b, a*a and b*b.
// A pair beyond MAX_LEN is not accumulated; it sets the overflow flag.
// item_stall is high whenever the sequencer is not idle.
// After the last pair the quotient unit runs: two 43-step shift-add
// products and a 16-bit root search, one bit per R_RTA/R_RTB/R_RTC pass,
// all on one 118-bit adder. A zero norm skips the quotient unit.
// Output channel (result, result_valid, result_stall): one transaction per
// vector pair. The result sits in an output register; while it is stalled
// new pairs are still accepted, and only the next final result waits.
// Reset clears all sums, the pair count, the overflow flag and result_valid.
// ----------------------------------------------------------------------------
module cosine_similarity_engine_top
    import csim_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  csim_in_t  item,
    input  logic      item_valid,
    output logic      item_stall,
    output csim_out_t result,
    output logic      result_valid,
    input  logic      result_stall
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MAB  = 3'd1;
    localparam logic [2:0] S_MAA  = 3'd2;
    localparam logic [2:0] S_MBB  = 3'd3;
    localparam logic [2:0] S_MEND = 3'd4;
    localparam logic [2:0] S_FIN  = 3'd5;
    localparam logic [2:0] S_WAIT = 3'd6;
    localparam logic [2:0] S_OUT  = 3'd7;

    localparam logic [MAG_W-1:0] SAT_TOP = MAG_W'((1 << FRAC_BITS) - 1);

    logic [2:0]                    state_reg, state_next;
    logic signed [DOT_W-1:0]       dot_reg, dot_next;
    logic [NORM_W-1:0]             na_reg, na_next;
    logic [NORM_W-1:0]             nb_reg, nb_next;
    logic [CNT_W-1:0]              count_reg, count_next;
    logic                          ovf_reg, ovf_next;
    logic                          res_valid_reg, res_valid_next;
    logic                          start_reg, start_next;

    logic signed [SAMPLE_BITS-1:0] a_reg, a_next;
    logic signed [SAMPLE_BITS-1:0] b_reg, b_next;
    logic                          last_reg, last_next;
    logic signed [PROD_W-1:0]      prod_reg, prod_next;
    logic signed [SIM_W-1:0]       sim_reg, sim_next;
    logic                          zero_reg, zero_next;
    csim_out_t                     res_reg, res_next;

    logic signed [SAMPLE_BITS-1:0] mul_x;
    logic signed [SAMPLE_BITS-1:0] mul_y;
    logic [DOT_W-1:0]              acc_op;
    logic [DOT_W-1:0]              acc_sum;
    logic                          item_take;
    logic                          res_free;
    logic                          dot_neg;
    logic [DOT_W-1:0]              dot_abs;
    csim_ratio_req_t               ratio_req;
    logic                          ratio_done;
    logic [MAG_W-1:0]              ratio_mag;

    assign item_take = item_valid && !item_stall;
    assign res_free  = !res_valid_reg || !result_stall;
    assign dot_neg   = dot_reg[DOT_W-1];
    assign dot_abs   = dot_neg ? DOT_W'(-dot_reg) : DOT_W'(dot_reg);

    assign ratio_req.dmag   = dot_abs[NORM_W-1:0];
    assign ratio_req.norm_a = na_reg;
    assign ratio_req.norm_b = nb_reg;

    // shared multiplier and accumulator adder
    always_comb
    begin
        mul_x  = a_reg;
        mul_y  = b_reg;
        acc_op = DOT_W'(dot_reg);
        case (state_reg)
            S_MAA:
            begin
                mul_y = a_reg;
            end
            S_MBB:
            begin
                mul_x  = b_reg;
                acc_op = {1'b0, na_reg};
            end
            S_MEND:
            begin
                acc_op = {1'b0, nb_reg};
            end
            default:
            begin
                acc_op = DOT_W'(dot_reg);
            end
        endcase
        acc_sum = acc_op + {{(DOT_W - PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
    end

    always_comb
    begin
        state_next     = state_reg;
        dot_next       = dot_reg;
        na_next        = na_reg;
        nb_next        = nb_reg;
        count_next     = count_reg;
        ovf_next       = ovf_reg;
        res_valid_next = res_valid_reg;
        start_next     = 1'b0;
        a_next         = a_reg;
        b_next         = b_reg;
        last_next      = last_reg;
        prod_next      = mul_x * mul_y;
        sim_next       = sim_reg;
        zero_next      = zero_reg;
        res_next       = res_reg;

        if (res_valid_reg && !result_stall)
        begin
            res_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (item_take)
                begin
                    a_next    = item.elem_a[SAMPLE_BITS-1:0];
                    b_next    = item.elem_b[SAMPLE_BITS-1:0];
                    last_next = item.last;
                    if (count_reg < CNT_W'(MAX_LEN))
                    begin
                        state_next = S_MAB;
                    end
                    else
                    begin
                        ovf_next   = 1'b1;
                        state_next = item.last ? S_FIN : S_IDLE;
                    end
                end
            end
            S_MAB:
            begin
                count_next = count_reg + 1'b1;
                state_next = S_MAA;
            end
            S_MAA:
            begin
                dot_next   = $signed(acc_sum);
                state_next = S_MBB;
            end
            S_MBB:
            begin
                na_next    = acc_sum[NORM_W-1:0];
                state_next = S_MEND;
            end
            S_MEND:
            begin
                nb_next    = acc_sum[NORM_W-1:0];
                state_next = last_reg ? S_FIN : S_IDLE;
            end
            S_FIN:
            begin
                if (na_reg == '0 || nb_reg == '0)
                begin
                    sim_next   = '0;
                    zero_next  = 1'b1;
                    state_next = S_OUT;
                end
                else
                begin
                    zero_next  = 1'b0;
                    start_next = 1'b1;
                    state_next = S_WAIT;
                end
            end
            S_WAIT:
            begin
                if (ratio_done)
                begin
                    if (dot_neg)
                    begin
                        sim_next = -$signed({1'b0, ratio_mag});
                    end
                    else
                    begin
                        sim_next = $signed({1'b0, ((ratio_mag > SAT_TOP) ? SAT_TOP : ratio_mag)});
                    end
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (res_free)
                begin
                    res_next.similarity      = SIM_OUT_W'(sim_reg);
                    res_next.zero_norm       = zero_reg;
                    res_next.length_overflow = ovf_reg;
                    res_valid_next           = 1'b1;
                    dot_next                 = '0;
                    na_next                  = '0;
                    nb_next                  = '0;
                    count_next               = '0;
                    ovf_next                 = 1'b0;
                    state_next               = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            dot_reg       <= '0;
            na_reg        <= '0;
            nb_reg        <= '0;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            res_valid_reg <= 1'b0;
            start_reg     <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            dot_reg       <= dot_next;
            na_reg        <= na_next;
            nb_reg        <= nb_next;
            count_reg     <= count_next;
            ovf_reg       <= ovf_next;
            res_valid_reg <= res_valid_next;
            start_reg     <= start_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg    <= a_next;
        b_reg    <= b_next;
        last_reg <= last_next;
        prod_reg <= prod_next;
        sim_reg  <= sim_next;
        zero_reg <= zero_next;
        res_reg  <= res_next;
    end

    csim_ratio u_ratio
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start_reg),
        .req   (ratio_req),
        .done  (ratio_done),
        .mag   (ratio_mag)
    );

    assign item_stall   = (state_reg != S_IDLE);
    assign result       = res_reg;
    assign result_valid = res_valid_reg;

endmodule
